@@ rtl/spd_pkg.sv @@
`timescale 1ns / 1ps

package spd_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 32;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 1024;

  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 10;
  localparam int SIZE_W  = 12;
  localparam int UP_W    = 13;
  localparam int COUNT_W = 11;
  localparam int END_W   = 14;
  localparam int ENTRY_W = 2 * SIZE_W;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NO_SPACE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot_index;
    logic [SIZE_W-1:0] data_len;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_out;
    logic [SIZE_W-1:0]  data_offset;
    logic [SIZE_W-1:0]  size_out;
    logic [UP_W-1:0]    free_bytes;
    logic [COUNT_W-1:0] live_count;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_GET,
    OP_DELETE,
    OP_UPDATE,
    OP_INIT,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
  } job_t;

  typedef struct packed {
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_CHECK,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

  // Byte just past the slot array when it holds n slots.
  function automatic logic [END_W-1:0] array_end(input logic [COUNT_W-1:0] n);
    return END_W'(HEADER_BYTES) + END_W'(n) * END_W'(SLOT_BYTES);
  endfunction

  function automatic logic [END_W-1:0] room_below(input logic [UP_W-1:0] up,
                                                  input logic [END_W-1:0] low);
    logic [END_W-1:0] up_w;
    up_w = END_W'(up);
    if (up_w > low) begin
      return up_w - low;
    end
    return '0;
  endfunction

endpackage

@@ rtl/slotted_page_directory.sv @@
`timescale 1ns / 1ps

// Slot directory of one slotted database page: insert, get, delete, update and
// init commands come in as words on req, and each gives exactly one word on rsp
// with status, slot, tuple offset, size, free bytes and live count. The host
// copies the tuple bytes to the returned offset itself. A two-word queue sits
// between the command decoder and the executing sequencer, so new words are
// taken while a result waits. A delete rescans the directory memory through
// its single read port. The directory memory needs no clearing after reset.
module slotted_page_directory (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spd_pkg::rsp_t rsp
);

  logic                           job_valid;
  logic                           job_ready;
  spd_pkg::job_t                  job;
  logic                           ram_wr_en;
  logic [spd_pkg::SLOT_W-1:0]     ram_wr_addr;
  logic [spd_pkg::ENTRY_W-1:0]    ram_wr_data;
  logic                           ram_rd_en;
  logic [spd_pkg::SLOT_W-1:0]     ram_rd_addr;
  logic [spd_pkg::ENTRY_W-1:0]    ram_rd_data;

  spd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  spd_ram #(
    .WIDTH (spd_pkg::ENTRY_W),
    .DEPTH (spd_pkg::MAX_SLOTS)
  ) u_dir_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  spd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

endmodule

@@ rtl/spd_ram.sv @@
`timescale 1ns / 1ps

module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/spd_front.sv @@
`timescale 1ns / 1ps

module spd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spd_pkg::req_t req,
  output logic          job_valid,
  input  logic          job_ready,
  output spd_pkg::job_t job
);

  spd_pkg::job_t job_in;
  spd_pkg::job_t q_mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  // Argument checks that need no directory state are settled here.
  always_comb begin
    job_in.slot = req.slot_index;
    job_in.size = req.data_len;
    unique case (req.cmd)
      spd_pkg::CMD_INSERT: begin
        job_in.slot = '0;
        job_in.op   = (req.data_len == '0) ? spd_pkg::OP_REJECT : spd_pkg::OP_INSERT;
      end
      spd_pkg::CMD_GET:    job_in.op = spd_pkg::OP_GET;
      spd_pkg::CMD_DELETE: job_in.op = spd_pkg::OP_DELETE;
      spd_pkg::CMD_UPDATE: begin
        job_in.op = (req.data_len == '0) ? spd_pkg::OP_REJECT : spd_pkg::OP_UPDATE;
      end
      spd_pkg::CMD_INIT:   job_in.op = spd_pkg::OP_INIT;
      default:             job_in.op = spd_pkg::OP_REJECT;
    endcase
  end

  assign req_ready = (count != 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = q_mem[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/spd_back.sv @@
`timescale 1ns / 1ps

module spd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  spd_pkg::job_t                       job,
  output logic                                ram_wr_en,
  output logic [spd_pkg::SLOT_W-1:0]          ram_wr_addr,
  output logic [spd_pkg::ENTRY_W-1:0]         ram_wr_data,
  output logic                                ram_rd_en,
  output logic [spd_pkg::SLOT_W-1:0]          ram_rd_addr,
  input  logic [spd_pkg::ENTRY_W-1:0]         ram_rd_data,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output spd_pkg::rsp_t                       rsp
);

  spd_pkg::back_state_t state, state_next;

  logic [spd_pkg::COUNT_W-1:0] slot_count, slot_count_next;
  logic [spd_pkg::COUNT_W-1:0] live, live_next;
  logic [spd_pkg::UP_W-1:0]    up, up_next;
  spd_pkg::job_t               cur, cur_next;
  logic [1:0]                  res_status, res_status_next;
  logic [spd_pkg::SLOT_W-1:0]  res_slot, res_slot_next;
  logic [spd_pkg::SIZE_W-1:0]  res_off, res_off_next;
  logic [spd_pkg::SIZE_W-1:0]  res_size, res_size_next;
  logic [spd_pkg::COUNT_W-1:0] scan_issue, scan_issue_next;
  logic                        scan_pend, scan_pend_next;
  logic [spd_pkg::UP_W-1:0]    scan_min, scan_min_next;
  logic                        rsp_valid_next;
  spd_pkg::rsp_t               rsp_next;

  spd_pkg::entry_t             rd_entry;
  spd_pkg::entry_t             wr_entry;
  logic [spd_pkg::END_W-1:0]   room_ins;
  logic [spd_pkg::END_W-1:0]   room_cur;
  logic [spd_pkg::SIZE_W-1:0]  new_off;

  assign rd_entry    = spd_pkg::entry_t'(ram_rd_data);
  assign ram_wr_data = spd_pkg::ENTRY_W'(wr_entry);
  assign room_ins    = spd_pkg::room_below(up, spd_pkg::array_end(slot_count + 11'd1));
  assign room_cur    = spd_pkg::room_below(up, spd_pkg::array_end(slot_count));
  assign new_off     = spd_pkg::SIZE_W'(up - spd_pkg::UP_W'(cur.size));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    slot_count_next = slot_count;
    live_next       = live;
    up_next         = up;
    cur_next        = cur;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_off_next    = res_off;
    res_size_next   = res_size;
    scan_issue_next = scan_issue;
    scan_pend_next  = scan_pend;
    scan_min_next   = scan_min;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    job_ready       = 1'b0;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = cur.slot;
    wr_entry.offset = new_off;
    wr_entry.size   = cur.size;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = cur.slot;

    unique case (state)
      spd_pkg::BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          cur_next   = job;
          state_next = spd_pkg::BK_EXEC;
        end
      end

      spd_pkg::BK_EXEC: begin
        res_status_next = spd_pkg::ST_OK;
        res_slot_next   = cur.slot;
        res_off_next    = '0;
        res_size_next   = '0;
        state_next      = spd_pkg::BK_FINISH;
        unique case (cur.op)
          spd_pkg::OP_INSERT: begin
            if (slot_count >= spd_pkg::COUNT_W'(spd_pkg::MAX_SLOTS) ||
                room_ins < spd_pkg::END_W'(cur.size)) begin
              res_status_next = spd_pkg::ST_NO_SPACE;
            end else begin
              ram_wr_en       = 1'b1;
              ram_wr_addr     = slot_count[spd_pkg::SLOT_W-1:0];
              res_slot_next   = slot_count[spd_pkg::SLOT_W-1:0];
              res_off_next    = new_off;
              res_size_next   = cur.size;
              up_next         = spd_pkg::UP_W'(new_off);
              slot_count_next = slot_count + 11'd1;
              live_next       = live + 11'd1;
            end
          end
          spd_pkg::OP_GET, spd_pkg::OP_DELETE, spd_pkg::OP_UPDATE: begin
            if (spd_pkg::COUNT_W'(cur.slot) >= slot_count) begin
              res_status_next = spd_pkg::ST_NOT_FOUND;
            end else begin
              ram_rd_en  = 1'b1;
              state_next = spd_pkg::BK_CHECK;
            end
          end
          spd_pkg::OP_INIT: begin
            slot_count_next = '0;
            live_next       = '0;
            up_next         = spd_pkg::UP_W'(spd_pkg::PAGE_BYTES);
          end
          default: begin
            res_status_next = spd_pkg::ST_INVALID;
          end
        endcase
      end

      spd_pkg::BK_CHECK: begin
        state_next = spd_pkg::BK_FINISH;
        if (rd_entry.size == '0) begin
          res_status_next = spd_pkg::ST_NOT_FOUND;
        end else if (cur.op == spd_pkg::OP_UPDATE) begin
          if (cur.size <= rd_entry.size) begin
            ram_wr_en       = 1'b1;
            wr_entry.offset = rd_entry.offset;
            res_off_next    = rd_entry.offset;
            res_size_next   = cur.size;
          end else if (room_cur < spd_pkg::END_W'(cur.size)) begin
            res_status_next = spd_pkg::ST_NO_SPACE;
          end else begin
            // A grown tuple moves just below the lowest live tuple.
            ram_wr_en     = 1'b1;
            res_off_next  = new_off;
            res_size_next = cur.size;
            up_next       = spd_pkg::UP_W'(new_off);
          end
        end else begin
          res_off_next  = rd_entry.offset;
          res_size_next = rd_entry.size;
          if (cur.op == spd_pkg::OP_DELETE) begin
            // Removing a tuple can raise the free-space bound, so rescan.
            ram_wr_en       = 1'b1;
            wr_entry.offset = rd_entry.offset;
            wr_entry.size   = '0;
            live_next       = live - 11'd1;
            scan_issue_next = '0;
            scan_pend_next  = 1'b0;
            scan_min_next   = spd_pkg::UP_W'(spd_pkg::PAGE_BYTES);
            state_next      = spd_pkg::BK_SCAN;
          end
        end
      end

      spd_pkg::BK_SCAN: begin
        if (scan_pend && rd_entry.size != '0 &&
            spd_pkg::UP_W'(rd_entry.offset) < scan_min) begin
          scan_min_next = spd_pkg::UP_W'(rd_entry.offset);
        end
        if (scan_issue < slot_count) begin
          ram_rd_en       = 1'b1;
          ram_rd_addr     = scan_issue[spd_pkg::SLOT_W-1:0];
          scan_issue_next = scan_issue + 11'd1;
          scan_pend_next  = 1'b1;
        end else begin
          scan_pend_next = 1'b0;
          if (!scan_pend) begin
            up_next    = scan_min;
            state_next = spd_pkg::BK_FINISH;
          end
        end
      end

      spd_pkg::BK_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.status       = res_status;
          rsp_next.slot_out     = res_slot;
          rsp_next.data_offset  = res_off;
          rsp_next.size_out     = res_size;
          rsp_next.free_bytes   = spd_pkg::UP_W'(room_cur);
          rsp_next.live_count   = live;
          rsp_valid_next        = 1'b1;
          state_next            = spd_pkg::BK_IDLE;
        end
      end

      default: begin
        state_next = spd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      live       <= '0;
      up         <= spd_pkg::UP_W'(spd_pkg::PAGE_BYTES);
      rsp_valid  <= 1'b0;
      scan_pend  <= 1'b0;
    end else begin
      slot_count <= slot_count_next;
      live       <= live_next;
      up         <= up_next;
      rsp_valid  <= rsp_valid_next;
      scan_pend  <= scan_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_off    <= res_off_next;
    res_size   <= res_size_next;
    scan_issue <= scan_issue_next;
    scan_min   <= scan_min_next;
    rsp        <= rsp_next;
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    slot_count <= spd_pkg::COUNT_W'(spd_pkg::MAX_SLOTS))
    else $error("slot count above the directory limit");

  a_live_le_count: assert property (@(posedge clk) disable iff (rst)
    live <= slot_count)
    else $error("live count above slot count");

  a_bound_max: assert property (@(posedge clk) disable iff (rst)
    up <= spd_pkg::UP_W'(spd_pkg::PAGE_BYTES))
    else $error("free-space bound beyond the page");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == spd_pkg::BK_EXEC || state == spd_pkg::BK_CHECK))
    else $error("directory write outside a command step");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == spd_pkg::BK_SCAN) |-> (slot_count != '0))
    else $error("scan of an empty directory");
`endif

endmodule
